>>> hw/rtl/lis_patience_tracker_assert.svh
// Assertion macros for the checker of the patience tracker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef LIS_PATIENCE_TRACKER_ASSERT_SVH
`define LIS_PATIENCE_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define LPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define LPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg
// Types and codes shared by the patience tracker, its checker and the bench.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned RunW    = 11;

  // Command codes of one input beat
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Input beat
  typedef struct packed {
    cmd_e                      cmd;
    logic signed [SampleW-1:0] sample_value;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [RunW-1:0]           run_length;
    logic signed [SampleW-1:0] out_value;
    logic                      out_valid;
    logic                      out_last;
    logic                      overflow;
  } rsp_t;

endpackage

>>> hw/rtl/lis_patience_tracker.sv
// ----------------------------------------------------------------------------
// lis_patience_tracker
// Longest non-decreasing subsequence tracker: binary search over the tail
// table on each push, predecessor walk on readout, under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | beat
//  ----------+-----------+----------------------+-----------------------
//  command   | in        | start high, busy low | req_i  (lpt_pkg::req_t)
//  result    | out       | done_o for one cycle | rsp_o  (lpt_pkg::rsp_t)
//
// A push runs a binary search through the tail RAM and the value RAM; each
// search step is a tail read, a value read and a compare, and there
// are up to log2(MAX_ITEMS) steps since a push only runs below capacity,
// followed by a predecessor read and a write. A read of an empty run, a
// clear, an unused code and a dropped push answer straight from idle; any
// other read passes through S_WPTR (first read of a walk only) and S_WDATA.
// Reset clears the counts and the walk state at once; the RAMs need no clearing.
// The result cannot be stalled; busy is low again in the strobe cycle.
// ----------------------------------------------------------------------------
module lis_patience_tracker #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lpt_pkg::req_t req_i,
  output lpt_pkg::rsp_t rsp_o,
  output logic          done_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_VAL,
    S_CMP,
    S_WRITE,
    S_WPTR,
    S_WDATA
  } state_e;

  state_e                             state_q, state_d;
  logic signed [lpt_pkg::SampleW-1:0] sample_q, sample_d;
  logic [CW-1:0]                      lo_q, lo_d;
  logic [CW-1:0]                      hi_q, hi_d;
  logic [CW-1:0]                      count_q, count_d;
  logic [CW-1:0]                      len_q, len_d;
  logic [IW-1:0]                      walk_q, walk_d;
  logic                               walk_act_q, walk_act_d;
  lpt_pkg::rsp_t                      rsp_q, rsp_d;
  logic                               done_q, done_d;

  logic [CW:0]                        sum;
  logic [CW-1:0]                      mid, lo_m1, len_m1;

  logic [IW-1:0]                      tail_raddr, val_raddr, pred_raddr;
  logic [IW-1:0]                      tail_rd;
  logic [lpt_pkg::SampleW-1:0]        val_rd;
  logic [IW:0]                        pred_rd;
  logic [IW:0]                        pred_wdata;
  logic                               wr_en;

  // Search midpoint and index helpers
  assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = sum[CW:1];
  assign lo_m1  = lo_q - CW'(1);
  assign len_m1 = len_q - CW'(1);

  // Steer the read addresses from the sequencer state
  always_comb begin
    tail_raddr = len_m1[IW-1:0];
    if (state_q == S_STEP) begin
      tail_raddr = (lo_q < hi_q) ? mid[IW-1:0] : lo_m1[IW-1:0];
    end
    val_raddr  = (state_q == S_VAL || state_q == S_WPTR) ? tail_rd : walk_q;
    pred_raddr = (state_q == S_WPTR) ? tail_rd : walk_q;
  end

  // Commit a push in the write cycle
  assign wr_en      = (state_q == S_WRITE);
  assign pred_wdata = (lo_q != '0) ? {1'b1, tail_rd} : '0;

  lpt_ram #(
    .Width (lpt_pkg::SampleW),
    .Depth (MAX_ITEMS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (sample_q),
    .raddr_i (val_raddr),
    .rdata_o (val_rd)
  );

  lpt_ram #(
    .Width (IW),
    .Depth (MAX_ITEMS)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (lo_q[IW-1:0]),
    .wdata_i (count_q[IW-1:0]),
    .raddr_i (tail_raddr),
    .rdata_o (tail_rd)
  );

  lpt_ram #(
    .Width (IW + 1),
    .Depth (MAX_ITEMS)
  ) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (pred_wdata),
    .raddr_i (pred_raddr),
    .rdata_o (pred_rd)
  );

  // Sequencer next state
  always_comb begin
    state_d    = state_q;
    sample_d   = sample_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    count_d    = count_q;
    len_d      = len_q;
    walk_d     = walk_q;
    walk_act_d = walk_act_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          sample_d       = req_i.sample_value;
          rsp_d          = '0;
          rsp_d.run_length = lpt_pkg::RunW'(len_q);
          unique case (req_i.cmd)
            lpt_pkg::CMD_PUSH: begin
              if (count_q == CW'(MAX_ITEMS)) begin
                rsp_d.overflow = 1'b1;
                done_d         = 1'b1;
              end else begin
                lo_d    = '0;
                hi_d    = len_q;
                state_d = S_STEP;
              end
            end
            lpt_pkg::CMD_READ: begin
              if (len_q == '0) begin
                done_d = 1'b1;
              end else if (walk_act_q) begin
                state_d = S_WDATA;
              end else begin
                state_d = S_WPTR;
              end
            end
            lpt_pkg::CMD_CLEAR: begin
              count_d          = '0;
              len_d            = '0;
              walk_d           = '0;
              walk_act_d       = 1'b0;
              rsp_d.run_length = '0;
              done_d           = 1'b1;
            end
            lpt_pkg::CMD_NONE: begin
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Issue the tail read at the midpoint, or finish the search
      S_STEP: begin
        state_d = (lo_q < hi_q) ? S_VAL : S_WRITE;
      end

      // Tail index is back; value read is under way
      S_VAL: begin
        state_d = S_CMP;
      end

      // Narrow the search range
      S_CMP: begin
        if ($signed(val_rd) > sample_q) begin
          hi_d = mid;
        end else begin
          lo_d = mid + CW'(1);
        end
        state_d = S_STEP;
      end

      // Store the sample, its predecessor and the new tail
      S_WRITE: begin
        if (lo_q == len_q) begin
          len_d = len_q + CW'(1);
        end
        count_d          = count_q + CW'(1);
        walk_act_d       = 1'b0;
        rsp_d.run_length = lpt_pkg::RunW'(len_d);
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end

      // Start the walk at the tail of the longest run
      S_WPTR: begin
        walk_d     = tail_rd;
        walk_act_d = 1'b1;
        state_d    = S_WDATA;
      end

      // Give one element and step to its predecessor
      S_WDATA: begin
        rsp_d.out_value = val_rd;
        rsp_d.out_valid = 1'b1;
        if (pred_rd[IW]) begin
          walk_d = pred_rd[IW-1:0];
        end else begin
          rsp_d.out_last = 1'b1;
          walk_act_d     = 1'b0;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      len_q      <= '0;
      walk_q     <= '0;
      walk_act_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      sample_q   <= sample_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      count_q    <= count_d;
      len_q      <= len_d;
      walk_q     <= walk_d;
      walk_act_q <= walk_act_d;
      rsp_q      <= rsp_d;
      done_q     <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

>>> hw/rtl/lpt_ram.sv
// ----------------------------------------------------------------------------
// lpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/lpt_checker.sv
// ----------------------------------------------------------------------------
// lpt_checker
// Port-level checks on the patience tracker, bound to its top level.
// ----------------------------------------------------------------------------
`include "lis_patience_tracker_assert.svh"

module lpt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input lpt_pkg::req_t req_i,
  input lpt_pkg::rsp_t rsp_o,
  input logic          done_o
);

  // A result beat comes only when the sequencer is back at rest
  `LPT_ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, done_o, !busy, "result while busy")

  // An accepted command either answers next cycle or keeps the block busy
  `LPT_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o, "command lost")

  // Every busy stretch ends with a result beat
  `LPT_ASSERT_IMP(a_busy_ends_done, clk_i, rst_ni, $fell(busy), done_o, "busy ended without result")

  // Readout elements only exist for a non-empty run, and never with overflow
  `LPT_ASSERT_IMP(a_valid_has_run, clk_i, rst_ni, done_o && rsp_o.out_valid, (rsp_o.run_length != '0) && !rsp_o.overflow, "readout beat inconsistent")

endmodule

bind lis_patience_tracker lpt_checker u_lpt_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lis_patience_tracker. Commands go in one beat at a
// time; an in-bench model of the patience tables predicts every result beat,
// and each strobed result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  import lpt_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned DRAIN_WAIT = 60;
  localparam int unsigned PRINT_MAX  = 100;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  rsp_t rsp_o;
  logic done_o;

  lis_patience_tracker #(
    .MAX_ITEMS(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .rsp_o (rsp_o),
    .done_o(done_o)
  );

  // Model of the patience tables
  logic signed [SampleW-1:0] lis_vals [DEPTH];
  int unsigned               lis_tail [DEPTH];
  int unsigned               lis_pred [DEPTH];
  bit                        lis_has_pred [DEPTH];
  int unsigned               lis_count = 0;
  int unsigned               lis_len = 0;
  int unsigned               walk_ptr = 0;
  bit                        walk_on = 1'b0;

  rsp_t        pending_rsp [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Predict the answer to one command and advance the model
  function automatic rsp_t predict_lis_answer(req_t r);
    rsp_t        a;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned idx;
    a = '0;
    case (r.cmd)
      CMD_PUSH: begin
        if (lis_count >= DEPTH) begin
          a.overflow = 1'b1;
        end else begin
          // First tail strictly greater than the sample
          lo = 0;
          hi = lis_len;
          while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (lis_vals[lis_tail[mid]] > r.sample_value) hi = mid;
            else lo = mid + 1;
          end
          idx = lis_count;
          lis_has_pred[idx] = (lo > 0);
          lis_pred[idx] = (lo > 0) ? lis_tail[lo - 1] : 0;
          lis_vals[idx] = r.sample_value;
          lis_tail[lo] = idx;
          if (lo == lis_len) lis_len++;
          lis_count++;
          walk_on = 1'b0;
        end
      end
      CMD_READ: begin
        if (lis_len > 0) begin
          if (!walk_on) begin
            walk_ptr = lis_tail[lis_len - 1];
            walk_on = 1'b1;
          end
          a.out_value = lis_vals[walk_ptr];
          a.out_valid = 1'b1;
          if (lis_has_pred[walk_ptr]) begin
            walk_ptr = lis_pred[walk_ptr];
          end else begin
            a.out_last = 1'b1;
            walk_on = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        lis_count = 0;
        lis_len = 0;
        walk_on = 1'b0;
        walk_ptr = 0;
      end
      default: begin
      end
    endcase
    a.run_length = RunW'(lis_len);
    return a;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_MAX)
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Check each result beat, then record the prediction for an accepted beat
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result", 32'(rsp_o.run_length), 32'h0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.run_length !== want.run_length)
            report_mismatch("run_length", 32'(rsp_o.run_length), 32'(want.run_length));
          if (rsp_o.out_value !== want.out_value)
            report_mismatch("out_value", rsp_o.out_value, want.out_value);
          if (rsp_o.out_valid !== want.out_valid)
            report_mismatch("out_valid", 32'(rsp_o.out_valid), 32'(want.out_valid));
          if (rsp_o.out_last !== want.out_last)
            report_mismatch("out_last", 32'(rsp_o.out_last), 32'(want.out_last));
          if (rsp_o.overflow !== want.overflow)
            report_mismatch("overflow", 32'(rsp_o.overflow), 32'(want.overflow));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_rsp.push_back(predict_lis_answer(req_i));
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
          $display("watchdog expired at %0t", $realtime);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Idle gap before a beat: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample drawn from a narrow or a medium band, the extremes or the full range
  function automatic logic signed [31:0] pick_sample(input int unsigned style);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 32'sh8000_0000;
    if (roll < 6) return 32'sh7fff_ffff;
    case (style)
      0: return $signed($urandom_range(0, 16)) - 8;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom();
    endcase
  endfunction

  // Send one command beat and wait until it is taken
  task automatic send_beat(input cmd_e c, input logic signed [SampleW-1:0] v);
    int unsigned gap;
    req_t        junk;
    req_t        beat;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      junk.cmd = cmd_e'($urandom_range(0, 3));
      junk.sample_value = $urandom();
      start <= 1'b0;
      req_i <= junk;
    end
    beat.cmd = c;
    beat.sample_value = v;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= beat;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Extremes, ties, walks, restarts and the unused code
  task automatic test_basics();
    idle_on = 1'b1;
    send_beat(CMD_CLEAR, 0);
    send_beat(CMD_READ, 0);
    send_beat(CMD_NONE, 32'sh7fff_ffff);
    send_beat(CMD_PUSH, 0);
    send_beat(CMD_PUSH, 32'sh8000_0000);
    send_beat(CMD_PUSH, 32'sh7fff_ffff);
    send_beat(CMD_PUSH, 32'sh7fff_ffff);
    send_beat(CMD_PUSH, 5);
    send_beat(CMD_PUSH, 5);
    send_beat(CMD_PUSH, -1);
    send_beat(CMD_READ, 0);
    send_beat(CMD_READ, 0);
    // Push in the middle of a walk cancels it
    send_beat(CMD_PUSH, 5);
    repeat (6) send_beat(CMD_READ, 0);
    send_beat(CMD_NONE, 0);
    send_beat(CMD_CLEAR, 0);
    send_beat(CMD_READ, 0);
    send_beat(CMD_PUSH, 32'sh8000_0000);
    send_beat(CMD_READ, 0);
    send_beat(CMD_READ, 0);
  endtask

  // Fill the store with a non-decreasing run, then push past capacity
  task automatic test_store_full();
    logic signed [SampleW-1:0] v;
    idle_on = 1'b0;
    send_beat(CMD_CLEAR, 0);
    v = 32'sh8000_0000;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if ($urandom_range(0, 3) != 0) v = v + $urandom_range(0, 4194303);
      if (i == DEPTH - 1) v = 32'sh7fff_ffff;
      send_beat(CMD_PUSH, v);
    end
    idle_on = 1'b1;
    send_beat(CMD_PUSH, 0);
    send_beat(CMD_PUSH, 32'sh8000_0000);
    repeat (3) send_beat(CMD_READ, 0);
    // A dropped push leaves the walk running
    send_beat(CMD_PUSH, 32'sh7fff_ffff);
    repeat (3) send_beat(CMD_READ, 0);
    send_beat(CMD_CLEAR, 0);
  endtask

  // Random sequences: pushes with reads, stray codes and early clears mixed in
  task automatic test_random_runs(input int unsigned beats);
    int unsigned sent;
    int unsigned pushes;
    int unsigned style;
    int unsigned roll;
    sent = 0;
    while (sent < beats) begin
      idle_on = ($urandom_range(0, 3) != 0);
      style = $urandom_range(0, 2);
      pushes = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 30);
      send_beat(CMD_CLEAR, pick_sample(2));
      sent++;
      for (int unsigned i = 0; i < pushes && sent < beats; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          repeat ($urandom_range(1, 20)) begin
            send_beat(CMD_READ, pick_sample(2));
            sent++;
          end
        end else if (roll < 11) begin
          send_beat(CMD_NONE, pick_sample(2));
          sent++;
        end else if (roll < 12) begin
          send_beat(CMD_CLEAR, pick_sample(2));
          sent++;
        end
        send_beat(CMD_PUSH, pick_sample(style));
        sent++;
      end
      // Read up to 40 elements of the walk, which may run past its end
      repeat ($urandom_range(0, 40)) begin
        send_beat(CMD_READ, pick_sample(2));
        sent++;
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basics();
    test_store_full();
    test_random_runs(850);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
